### sv/vector_normalize_core_macros.svh
// Assertion macros shared by the vector normalize RTL.
`ifndef VECTOR_NORMALIZE_CORE_MACROS_SVH
`define VECTOR_NORMALIZE_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define VN_ASSERT_IMPLY(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define VN_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

### sv/vn_pkg.sv
// Types and constants shared by the vector normalize modules.
`default_nettype none
package vn_pkg;
   localparam int DATA_W    = 32;
   localparam int SQ_W      = 64;
   localparam int ROOT_W    = 32;
   localparam int REM_W     = 35;
   localparam int QUOT_W    = 31;
   localparam int SHIFT_W   = 5;
   localparam int UNIT_FRAC = 30;
   localparam logic [DATA_W-1:0] UNIT_ONE = DATA_W'(64'd1 << UNIT_FRAC);

   typedef struct packed {
      logic signed [DATA_W-1:0] vec_x;
      logic signed [DATA_W-1:0] vec_y;
      logic signed [DATA_W-1:0] vec_z;
      logic                     two_dim;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] norm_x;
      logic signed [DATA_W-1:0] norm_y;
      logic signed [DATA_W-1:0] norm_z;
      logic [DATA_W-1:0]        length;
      logic                     zero_vector;
   } rsp_type;

   // Per-item data that rides beside the square root pipeline.
   typedef struct packed {
      logic [2:0][DATA_W-1:0] mag;
      logic [2:0]             neg;
      logic [SHIFT_W-1:0]     shift;
      logic                   zero;
   } side_type;
endpackage
`default_nettype wire

### sv/vn_req_if.sv
// Request channel interface for the vector normalize core.
`default_nettype none
interface vn_req_if;
   logic             valid;
   logic             ready;
   vn_pkg::req_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

### sv/vn_rsp_if.sv
// Response channel interface for the vector normalize core.
`default_nettype none
interface vn_rsp_if;
   logic             valid;
   logic             ready;
   vn_pkg::rsp_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

### sv/vn_front.sv
// Front pipeline: sign extension, magnitudes, squares, sum and even normalizing shift.
`default_nettype none
module vn_front #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  vn_pkg::req_type               in_data,
   output logic                          out_valid,
   output logic [vn_pkg::SQ_W-1:0]       out_sn,
   output vn_pkg::side_type              out_side
);
   import vn_pkg::*;

   localparam int EFF_W  = (COORD_WIDTH > DATA_W) ? DATA_W : COORD_WIDTH;
   localparam int EXT_SH = DATA_W - EFF_W;

   logic [2:0][DATA_W-1:0] raw;
   logic [2:0][DATA_W-1:0] mag_in;
   logic [2:0]             neg_in;

   logic                   s1_valid_ff;
   logic [2:0][DATA_W-1:0] s1_mag_ff;
   logic [2:0]             s1_neg_ff;

   logic                   s2_valid_ff;
   logic [2:0][SQ_W-1:0]   s2_sq_ff;
   logic [2:0][DATA_W-1:0] s2_mag_ff;
   logic [2:0]             s2_neg_ff;

   logic                   ns_valid_ff [0:5];
   logic [SQ_W-1:0]        ns_sn_ff    [0:5];
   side_type               ns_side_ff  [0:5];

   assign raw = {in_data.vec_z, in_data.vec_y, in_data.vec_x};

   always_comb begin
      logic signed [DATA_W-1:0] ext;
      ext    = '0;
      mag_in = '0;
      neg_in = '0;
      for (int c = 0; c < 3; c++) begin
         ext       = $signed(raw[c] << EXT_SH) >>> EXT_SH;
         neg_in[c] = ext[DATA_W-1];
         mag_in[c] = ext[DATA_W-1] ? DATA_W'(-ext) : DATA_W'(ext);
      end
      if (in_data.two_dim) begin
         mag_in[2] = '0;
         neg_in[2] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         ns_valid_ff[0] <= 1'b0;
      end else if (adv) begin
         s1_valid_ff    <= in_valid;
         s2_valid_ff    <= s1_valid_ff;
         ns_valid_ff[0] <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_mag_ff <= mag_in;
         s1_neg_ff <= neg_in;
         for (int c = 0; c < 3; c++) begin
            s2_sq_ff[c] <= SQ_W'(s1_mag_ff[c]) * SQ_W'(s1_mag_ff[c]);
         end
         s2_mag_ff     <= s1_mag_ff;
         s2_neg_ff     <= s1_neg_ff;
         ns_sn_ff[0]   <= s2_sq_ff[0] + s2_sq_ff[1] + s2_sq_ff[2];
         ns_side_ff[0] <= '{mag: s2_mag_ff, neg: s2_neg_ff, shift: '0, zero: 1'b0};
      end
   end

   // Shift the sum left by an even amount until one of its top two bits is set.
   for (genvar j = 0; j < 5; j++) begin : g_norm
      localparam int AMT = 32 >> j;
      side_type        side_in;
      logic [SQ_W-1:0] sn_in;

      always_comb begin
         side_in = ns_side_ff[j];
         sn_in   = ns_sn_ff[j];
         if (j == 0) begin
            side_in.zero = (ns_sn_ff[j] == '0);
         end
         if (ns_sn_ff[j][SQ_W-1 -: AMT] == '0) begin
            sn_in         = ns_sn_ff[j] << AMT;
            side_in.shift = ns_side_ff[j].shift + SHIFT_W'(AMT / 2);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ns_valid_ff[j+1] <= 1'b0;
         end else if (adv) begin
            ns_valid_ff[j+1] <= ns_valid_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            ns_sn_ff[j+1]   <= sn_in;
            ns_side_ff[j+1] <= side_in;
         end
      end
   end

   assign out_valid = ns_valid_ff[5];
   assign out_sn    = ns_sn_ff[5];
   assign out_side  = ns_side_ff[5];
endmodule
`default_nettype wire

### sv/vn_sqrt.sv
// Pipelined restoring square root, one root bit per stage.
`default_nettype none
module vn_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  logic [vn_pkg::SQ_W-1:0]       in_sn,
   input  vn_pkg::side_type              in_side,
   output logic                          out_valid,
   output logic [vn_pkg::ROOT_W-1:0]     out_root,
   output vn_pkg::side_type              out_side
);
   import vn_pkg::*;

   logic              valid_ff [0:ROOT_W-1];
   logic [SQ_W-1:0]   sn_ff    [0:ROOT_W-1];
   logic [REM_W-1:0]  rem_ff   [0:ROOT_W-1];
   logic [ROOT_W-1:0] root_ff  [0:ROOT_W-1];
   side_type          side_ff  [0:ROOT_W-1];

   for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
      logic              valid_prev;
      logic [SQ_W-1:0]   sn_prev;
      logic [REM_W-1:0]  rem_prev;
      logic [ROOT_W-1:0] root_prev;
      side_type          side_prev;
      logic [REM_W-1:0]  cur;
      logic [REM_W-1:0]  trial;
      logic [REM_W-1:0]  rem_in;
      logic [ROOT_W-1:0] root_in;

      if (i == 0) begin : g_first
         assign valid_prev = in_valid;
         assign sn_prev    = in_sn;
         assign rem_prev   = '0;
         assign root_prev  = '0;
         assign side_prev  = in_side;
      end else begin : g_next
         assign valid_prev = valid_ff[i-1];
         assign sn_prev    = sn_ff[i-1];
         assign rem_prev   = rem_ff[i-1];
         assign root_prev  = root_ff[i-1];
         assign side_prev  = side_ff[i-1];
      end

      // The remainder never exceeds twice the partial root, so 33 bits carry it.
      assign cur   = {rem_prev[REM_W-3:0], sn_prev[SQ_W-1-2*i -: 2]};
      assign trial = {1'b0, root_prev, 2'b01};

      always_comb begin
         if (cur >= trial) begin
            rem_in  = cur - trial;
            root_in = {root_prev[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = cur;
            root_in = {root_prev[ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (adv) begin
            valid_ff[i] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sn_ff[i]   <= sn_prev;
            rem_ff[i]  <= rem_in;
            root_ff[i] <= root_in;
            side_ff[i] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_side  = side_ff[ROOT_W-1];
endmodule
`default_nettype wire

### sv/vn_div.sv
// Pipelined three-lane restoring divider giving each component over the root.
`default_nettype none
module vn_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 adv,
   input  logic                                 in_valid,
   input  logic [vn_pkg::ROOT_W-1:0]            in_root,
   input  vn_pkg::side_type                     in_side,
   output logic                                 out_valid,
   output logic [2:0][vn_pkg::QUOT_W-1:0]       out_quot,
   output logic [2:0]                           out_neg,
   output logic [vn_pkg::DATA_W-1:0]            out_length,
   output logic                                 out_zero
);
   import vn_pkg::*;

   localparam int STAGES = QUOT_W;

   logic                   valid_ff [0:STAGES-1];
   logic [ROOT_W-1:0]      root_ff  [0:STAGES-1];
   logic [2:0][ROOT_W-1:0] rem_ff   [0:STAGES-1];
   logic [2:0][QUOT_W-1:0] quot_ff  [0:STAGES-1];
   logic [2:0]             neg_ff   [0:STAGES-1];
   logic [DATA_W-1:0]      len_ff   [0:STAGES-1];
   logic                   zero_ff  [0:STAGES-1];

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      logic [2:0][ROOT_W-1:0] rem_in;
      logic [2:0][QUOT_W-1:0] quot_in;

      if (i == 0) begin : g_first
         // Integer step: the scaled magnitude never exceeds the root.
         always_comb begin
            logic [ROOT_W-1:0] m;
            m       = '0;
            rem_in  = '0;
            quot_in = '0;
            for (int c = 0; c < 3; c++) begin
               m = in_side.mag[c] << in_side.shift;
               if (m >= in_root) begin
                  rem_in[c]  = m - in_root;
                  quot_in[c] = QUOT_W'(1);
               end else begin
                  rem_in[c]  = m;
               end
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[0] <= 1'b0;
            end else if (adv) begin
               valid_ff[0] <= in_valid;
            end
         end

         always_ff @(posedge clock) begin
            if (adv) begin
               root_ff[0] <= in_root;
               rem_ff[0]  <= rem_in;
               quot_ff[0] <= quot_in;
               neg_ff[0]  <= in_side.neg;
               len_ff[0]  <= DATA_W'(in_root >> in_side.shift);
               zero_ff[0] <= in_side.zero;
            end
         end
      end else begin : g_frac
         always_comb begin
            logic [ROOT_W:0] twice;
            twice   = '0;
            rem_in  = '0;
            quot_in = '0;
            for (int c = 0; c < 3; c++) begin
               twice = {rem_ff[i-1][c], 1'b0};
               if (twice >= {1'b0, root_ff[i-1]}) begin
                  rem_in[c]  = ROOT_W'(twice - {1'b0, root_ff[i-1]});
                  quot_in[c] = {quot_ff[i-1][c][QUOT_W-2:0], 1'b1};
               end else begin
                  rem_in[c]  = twice[ROOT_W-1:0];
                  quot_in[c] = {quot_ff[i-1][c][QUOT_W-2:0], 1'b0};
               end
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[i] <= 1'b0;
            end else if (adv) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end

         always_ff @(posedge clock) begin
            if (adv) begin
               root_ff[i] <= root_ff[i-1];
               rem_ff[i]  <= rem_in;
               quot_ff[i] <= quot_in;
               neg_ff[i]  <= neg_ff[i-1];
               len_ff[i]  <= len_ff[i-1];
               zero_ff[i] <= zero_ff[i-1];
            end
         end
      end
   end

   assign out_valid  = valid_ff[STAGES-1];
   assign out_quot   = quot_ff[STAGES-1];
   assign out_neg    = neg_ff[STAGES-1];
   assign out_length = len_ff[STAGES-1];
   assign out_zero   = zero_ff[STAGES-1];
endmodule
`default_nettype wire

### sv/vector_normalize_core.sv
// Top level of the pipelined 2-D/3-D vector normalize core.
//
//   Channel   Direction  Carries
//   req_chan  in         vec_x, vec_y, vec_z (Q16.16), two_dim
//   rsp_chan  out        norm_x, norm_y, norm_z (Q2.30), length (Q16.16), zero_vector
//
// One request is taken every cycle while the output does not stall; each result
// passes through 8 front stages, 32 square root stages, 31 divider stages and
// the output register. Reset is synchronous and clears only the valid bits.
// All stages share one advance signal, so a stall at the output freezes the
// whole pipeline and the request side sees ready low in the same cycle.
`default_nettype none
`include "vector_normalize_core_macros.svh"
module vector_normalize_core #(
   parameter int COORD_WIDTH = 32
) (
   input  logic      clock,
   input  logic      reset,
   vn_req_if.sink    req_chan,
   vn_rsp_if.source  rsp_chan
);
   import vn_pkg::*;

   logic                   adv;
   logic                   fr_valid;
   logic [SQ_W-1:0]        fr_sn;
   side_type               fr_side;
   logic                   sq_valid;
   logic [ROOT_W-1:0]      sq_root;
   side_type               sq_side;
   logic                   dv_valid;
   logic [2:0][QUOT_W-1:0] dv_quot;
   logic [2:0]             dv_neg;
   logic [DATA_W-1:0]      dv_length;
   logic                   dv_zero;
   logic [2:0][DATA_W-1:0] norm_in;
   logic                   rsp_valid_ff;
   rsp_type                rsp_data_ff;

   assign adv            = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = adv;

   vn_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_chan.valid),
      .in_data   (req_chan.payload),
      .out_valid (fr_valid),
      .out_sn    (fr_sn),
      .out_side  (fr_side)
   );

   vn_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (fr_valid),
      .in_sn     (fr_sn),
      .in_side   (fr_side),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   vn_div u_div (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_valid   (sq_valid),
      .in_root    (sq_root),
      .in_side    (sq_side),
      .out_valid  (dv_valid),
      .out_quot   (dv_quot),
      .out_neg    (dv_neg),
      .out_length (dv_length),
      .out_zero   (dv_zero)
   );

   // Clamp at exactly one, apply the sign, and clear everything for a zero vector.
   always_comb begin
      logic [DATA_W-1:0] sat;
      sat     = '0;
      norm_in = '0;
      for (int c = 0; c < 3; c++) begin
         sat = ({1'b0, dv_quot[c]} > UNIT_ONE) ? UNIT_ONE : {1'b0, dv_quot[c]};
         if (!dv_zero) begin
            norm_in[c] = dv_neg[c] ? DATA_W'(-sat) : sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff.norm_x      <= norm_in[0];
         rsp_data_ff.norm_y      <= norm_in[1];
         rsp_data_ff.norm_z      <= norm_in[2];
         rsp_data_ff.length      <= dv_zero ? '0 : dv_length;
         rsp_data_ff.zero_vector <= dv_zero;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   `VN_ASSERT_IMPLY(a_zero_clean, clock, reset, rsp_valid_ff && rsp_data_ff.zero_vector, (rsp_data_ff.norm_x == 0) && (rsp_data_ff.norm_y == 0) && (rsp_data_ff.norm_z == 0) && (rsp_data_ff.length == 0), "zero vector result has nonzero fields")
   `VN_ASSERT_IMPLY(a_len_nonzero, clock, reset, rsp_valid_ff && !rsp_data_ff.zero_vector, rsp_data_ff.length != 0, "nonzero vector gave zero length")
   `VN_ASSERT_IMPLY(a_root_normal, clock, reset, sq_valid && !sq_side.zero, sq_root[ROOT_W-1], "normalized root lost its top bit")
endmodule
`default_nettype wire

### bench/tb_vector_normalize_core.sv
// Self-checking testbench for the vector normalize core.
`timescale 1ns / 1ps
`default_nettype none
module tb_vector_normalize_core;
   import vn_pkg::*;

   localparam int LATENCY = 72;
   localparam int WATCHDOG_LIMIT = 20000;

   logic clock;
   logic reset;

   vn_req_if req_chan ();
   vn_rsp_if rsp_chan ();

   vector_normalize_core #(.COORD_WIDTH(32)) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   rsp_type expected_norms[$];
   int      error_count;
   int      send_idle_pct;
   int      stall_pct;
   bit      hold_off;
   int      idle_cycles;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Magnitude of a signed 64-bit value as unsigned.
   function automatic logic [63:0] abs64(input logic signed [63:0] v);
      return v < 0 ? 64'd0 - 64'(v) : 64'(v);
   endfunction

   function automatic logic [63:0] root64(input logic [63:0] x);
      logic [63:0] rem;
      logic [63:0] root;
      logic [63:0] bitv;
      rem = x;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > rem) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (rem >= root + bitv) begin
            rem = rem - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function automatic logic [31:0] unit_of(input logic signed [63:0] v, input int k,
                                          input logic [63:0] root);
      logic [63:0] q;
      q = ((abs64(v) << k) << UNIT_FRAC) / root;
      if (q > (64'd1 << UNIT_FRAC)) q = 64'd1 << UNIT_FRAC;
      if (v < 0) q = 64'd0 - q;
      return q[31:0];
   endfunction

   function automatic rsp_type normalize(input req_type r);
      logic signed [63:0] comp[3];
      logic [63:0]        sum_sq;
      logic [63:0]        shifted;
      logic [63:0]        root;
      int                 k;
      rsp_type            res;
      comp[0] = 64'(r.vec_x);
      comp[1] = 64'(r.vec_y);
      comp[2] = r.two_dim ? 64'sd0 : 64'(r.vec_z);
      sum_sq = 0;
      for (int i = 0; i < 3; i++) sum_sq = sum_sq + abs64(comp[i]) * abs64(comp[i]);
      res = '0;
      if (sum_sq == 0) begin
         res.zero_vector = 1'b1;
         return res;
      end
      shifted = sum_sq;
      k = 0;
      while (shifted < (64'd1 << 62)) begin
         shifted = shifted << 2;
         k++;
      end
      root = root64(shifted);
      res.norm_x = unit_of(comp[0], k, root);
      res.norm_y = unit_of(comp[1], k, root);
      res.norm_z = unit_of(comp[2], k, root);
      res.length = 32'(root >> k);
      return res;
   endfunction

   // Called at a falling edge; valid stays high after the request so that
   // the next request can follow without a gap.
   task automatic send_vector(input req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         req_chan.payload <= req_type'({$urandom, $urandom, $urandom, 1'b0});
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.payload <= r;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      expected_norms.push_back(normalize(r));
      @(negedge clock);
   endtask

   function automatic logic [31:0] random_coord();
      case ($urandom_range(5))
         0: return $urandom_range(255);
         1: return -$urandom_range(255);
         2: return $urandom >> $urandom_range(31);
         3: return {$urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff};
         default: return $urandom;
      endcase
   endfunction

   task automatic send_random(input int count);
      req_type r;
      for (int i = 0; i < count; i++) begin
         r.vec_x = random_coord();
         r.vec_y = random_coord();
         r.vec_z = random_coord();
         r.two_dim = 1'($urandom_range(1));
         if ($urandom_range(19) == 0) begin
            r.vec_x = 0;
            r.vec_y = 0;
            if ($urandom_range(1)) r.vec_z = 0;
         end
         send_vector(r);
      end
   endtask

   // Called at a falling edge; drops valid and returns at a falling edge.
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      req_chan.payload <= req_type'({$urandom, $urandom, $urandom, 1'b0});
      while (expected_norms.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic test_directed();
      logic [31:0] edges[6];
      edges = '{32'h0, 32'h1, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000};
      send_idle_pct = 0;
      stall_pct = 0;
      send_vector('{vec_x: 0, vec_y: 0, vec_z: 0, two_dim: 0});
      send_vector('{vec_x: 0, vec_y: 0, vec_z: 32'h1234, two_dim: 1});
      send_vector('{vec_x: 32'h8000_0000, vec_y: 32'h8000_0000, vec_z: 32'h8000_0000,
                    two_dim: 0});
      send_vector('{vec_x: 32'h7fff_ffff, vec_y: 32'h7fff_ffff, vec_z: 32'h7fff_ffff,
                    two_dim: 1});
      send_vector('{vec_x: 32'h0003_0000, vec_y: 32'h0004_0000, vec_z: 0, two_dim: 1});
      send_vector('{vec_x: 0, vec_y: 0, vec_z: 32'hffff_ffff, two_dim: 0});
      for (int i = 0; i < 6; i++)
         send_vector('{vec_x: edges[i], vec_y: edges[5 - i], vec_z: edges[(i + 2) % 6],
                       two_dim: i[0]});
      wait_drained();
   endtask

   task automatic test_idling();
      int pct[4][2];
      pct = '{'{0, 0}, '{72, 0}, '{0, 72}, '{19, 19}};
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = pct[p][0];
         stall_pct = pct[p][1];
         send_random(180);
      end
      wait_drained();
   endtask

   // The receiver holds off long enough for the pipeline to fill and block requests.
   task automatic test_backpressure();
      send_idle_pct = 0;
      stall_pct = 0;
      hold_off = 1'b1;
      send_random(100);
      wait_drained();
      send_random(30);
   endtask

   initial begin
      int hold_count;
      hold_off = 1'b0;
      hold_count = 0;
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_chan.ready <= 1'b0;
            hold_count++;
            if (hold_count >= 300) begin
               hold_off = 1'b0;
               hold_count = 0;
            end
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_norms.size() == 0) begin
            $error("unexpected result");
            error_count++;
         end else begin
            rsp_type exp_r;
            exp_r = expected_norms.pop_front();
            if (rsp_chan.payload.norm_x !== exp_r.norm_x) begin
               $error("norm_x expected %h actual %h", exp_r.norm_x, rsp_chan.payload.norm_x);
               error_count++;
            end
            if (rsp_chan.payload.norm_y !== exp_r.norm_y) begin
               $error("norm_y expected %h actual %h", exp_r.norm_y, rsp_chan.payload.norm_y);
               error_count++;
            end
            if (rsp_chan.payload.norm_z !== exp_r.norm_z) begin
               $error("norm_z expected %h actual %h", exp_r.norm_z, rsp_chan.payload.norm_z);
               error_count++;
            end
            if (rsp_chan.payload.length !== exp_r.length) begin
               $error("length expected %h actual %h", exp_r.length, rsp_chan.payload.length);
               error_count++;
            end
            if (rsp_chan.payload.zero_vector !== exp_r.zero_vector) begin
               $error("zero_vector expected %b actual %b", exp_r.zero_vector,
                      rsp_chan.payload.zero_vector);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      error_count = 0;
      idle_cycles = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_idling();
      test_backpressure();
      wait_drained();
      repeat (LATENCY + 10) @(posedge clock);
      if (error_count == 0 && expected_norms.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule
`default_nettype wire
